// ===== design/card_number_luhn_classifier_top_assert.svh =====
// ----------------------------------------------------------------------------
// Card number classifier assertion macros
// Shared property forms for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef CARD_NUMBER_LUHN_CLASSIFIER_TOP_ASSERT_SVH
`define CARD_NUMBER_LUHN_CLASSIFIER_TOP_ASSERT_SVH

// Same-cycle implication, clocked on i_clk, off during reset.
`define CNLC_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("cnlc check failed");

// Next-cycle implication, clocked on i_clk, off during reset.
`define CNLC_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("cnlc check failed");

`endif

// ===== design/cnlc_pkg.sv =====
// ----------------------------------------------------------------------------
// Card number classifier package
// Shared widths, class codes, command/status types and digit helpers.
// ----------------------------------------------------------------------------
package cnlc_pkg;

    localparam int IN_W   = 63;
    localparam int CLS_W  = 2;
    localparam int DCNT_W = 5;

    // issuer class codes
    localparam logic [CLS_W-1:0] CLS_INVALID = 2'd0;
    localparam logic [CLS_W-1:0] CLS_PFX4    = 2'd1;
    localparam logic [CLS_W-1:0] CLS_PFX3X   = 2'd2;
    localparam logic [CLS_W-1:0] CLS_PFX5X   = 2'd3;

    // accepted lengths
    localparam logic [DCNT_W-1:0] LEN_13 = 5'd13;
    localparam logic [DCNT_W-1:0] LEN_15 = 5'd15;
    localparam logic [DCNT_W-1:0] LEN_16 = 5'd16;

    typedef struct packed {
        logic load_in;
        logic conv_step;
        logic luhn_step;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic conv_last;
        logic luhn_last;
    } t_sts;

    // doubled digit folded back to one digit
    function automatic logic [3:0] luhn_dbl(input logic [3:0] d);
        logic [4:0] v;
        v = {d, 1'b0};
        if (v > 5'd9) begin
            v = v - 5'd9;
        end
        return v[3:0];
    endfunction

    // running sum kept mod 10
    function automatic logic [3:0] add_mod10(input logic [3:0] a, input logic [3:0] b);
        logic [4:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= 5'd10) begin
            s = s - 5'd10;
        end
        return s[3:0];
    endfunction

    // class from length and the two leading digits
    function automatic logic [CLS_W-1:0] prefix_class(
        input logic [DCNT_W-1:0] cnt,
        input logic [3:0]        lead,
        input logic [3:0]        lead2
    );
        logic [CLS_W-1:0] c;
        c = CLS_INVALID;
        if (cnt == LEN_13 && lead == 4'd4) begin
            c = CLS_PFX4;
        end else if (cnt == LEN_15 && lead == 4'd3 && (lead2 == 4'd4 || lead2 == 4'd7)) begin
            c = CLS_PFX3X;
        end else if (cnt == LEN_16) begin
            if (lead == 4'd5 && lead2 >= 4'd1 && lead2 <= 4'd5) begin
                c = CLS_PFX5X;
            end else if (lead == 4'd4) begin
                c = CLS_PFX4;
            end
        end
        return c;
    endfunction

endpackage

// ===== design/cnlc_ctrl.sv =====
// ----------------------------------------------------------------------------
// Card number classifier controller
// Sequences conversion, Luhn pass and result load; owns the handshakes.
// ----------------------------------------------------------------------------
module cnlc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  cnlc_pkg::t_sts i_sts,
    output cnlc_pkg::t_cmd o_cmd
);
    import cnlc_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_CONV, S_LUHN, S_WAIT} t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_slot_free;

    assign w_slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_cmd           = '0;
        o_cmd.load_in   = (r_state == S_IDLE) && i_in_valid;
        o_cmd.conv_step = (r_state == S_CONV);
        o_cmd.luhn_step = (r_state == S_LUHN);
        o_cmd.load_out  = (r_state == S_WAIT) && w_slot_free;
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                if (i_sts.conv_last) begin
                    n_state = S_LUHN;
                end
            end
            S_LUHN: begin
                if (i_sts.luhn_last) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (w_slot_free) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== design/cnlc_dp.sv =====
// ----------------------------------------------------------------------------
// Card number classifier datapath
// Shift-add-3 binary to BCD, digit-serial Luhn pass, result registers.
// ----------------------------------------------------------------------------
module cnlc_dp #(
    parameter int MAX_DIGITS = 19
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  cnlc_pkg::t_cmd               i_cmd,
    output cnlc_pkg::t_sts               o_sts,
    input  logic [cnlc_pkg::IN_W-1:0]    i_card_number,
    output logic [cnlc_pkg::CLS_W-1:0]   o_issuer_class,
    output logic [cnlc_pkg::DCNT_W-1:0]  o_digit_count,
    output logic                         o_checksum_ok
);
    import cnlc_pkg::*;

    localparam int BCD_W  = 4 * MAX_DIGITS;
    localparam int STEP_W = $clog2(IN_W);
    localparam int IDX_W  = $clog2(MAX_DIGITS + 1);

    logic [IN_W-1:0]   r_bin;
    logic [BCD_W-1:0]  r_bcd;
    logic [BCD_W-1:0]  w_adj;
    logic [STEP_W-1:0] r_step;
    logic [IDX_W-1:0]  r_idx;
    logic              r_ovf;
    logic [3:0]        r_sum;
    logic [DCNT_W-1:0] r_count;
    logic [3:0]        r_prev;
    logic [3:0]        r_lead;
    logic [3:0]        r_lead2;
    logic [3:0]        w_dig;
    logic [3:0]        w_luhn;
    logic              w_ok;

    logic [CLS_W-1:0]  r_cls_q;
    logic [DCNT_W-1:0] r_cnt_q;
    logic              r_ok_q;

    // add 3 to every digit of 5 or more before the shift
    always_comb begin
        for (int k = 0; k < MAX_DIGITS; k++) begin
            w_adj[4*k +: 4] = (r_bcd[4*k +: 4] >= 4'd5) ? r_bcd[4*k +: 4] + 4'd3
                                                        : r_bcd[4*k +: 4];
        end
    end

    assign w_dig  = r_bcd[3:0];
    assign w_luhn = r_idx[0] ? luhn_dbl(w_dig) : w_dig;

    assign o_sts.conv_last = (r_step == STEP_W'(IN_W - 1));
    assign o_sts.luhn_last = (r_idx == IDX_W'(MAX_DIGITS - 1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_bin   <= i_card_number;
            r_bcd   <= '0;
            r_step  <= '0;
            r_idx   <= '0;
            r_ovf   <= 1'b0;
            r_sum   <= '0;
            r_count <= '0;
            r_prev  <= '0;
            r_lead  <= '0;
            r_lead2 <= '0;
        end else if (i_cmd.conv_step) begin
            r_bin  <= {r_bin[IN_W-2:0], 1'b0};
            r_bcd  <= {w_adj[BCD_W-2:0], r_bin[IN_W-1]};
            r_ovf  <= r_ovf | w_adj[BCD_W-1];   // value reached 10^MAX_DIGITS
            r_step <= r_step + 1'b1;
        end else if (i_cmd.luhn_step) begin
            r_bcd <= {4'b0000, r_bcd[BCD_W-1:4]};
            r_sum <= add_mod10(r_sum, w_luhn);
            if (w_dig != 4'd0) begin
                r_count <= DCNT_W'(r_idx) + 1'b1;
                r_lead  <= w_dig;
                r_lead2 <= r_prev;
            end
            r_prev <= w_dig;
            r_idx  <= r_idx + 1'b1;
        end
    end

    assign w_ok = !r_ovf && (r_count != '0) && (r_sum == 4'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ok_q  <= 1'b0;
            r_cnt_q <= '0;
            r_cls_q <= CLS_INVALID;
        end else if (i_cmd.load_out) begin
            r_ok_q  <= w_ok;
            r_cnt_q <= r_ovf ? DCNT_W'(MAX_DIGITS) : r_count;
            r_cls_q <= w_ok ? prefix_class(r_count, r_lead, r_lead2) : CLS_INVALID;
        end
    end

    assign o_issuer_class = r_cls_q;
    assign o_digit_count  = r_cnt_q;
    assign o_checksum_ok  = r_ok_q;

endmodule

// ===== design/card_number_luhn_classifier_top.sv =====
// ----------------------------------------------------------------------------
// Card number classifier top level
// Luhn mod-10 check with length/prefix issuer classification.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel  (i_in_valid / o_in_ready) carries one item: a 63-bit
//   unsigned card number. Output channel (o_out_valid / i_out_ready)
//   returns one item per input: issuer class, digit count, checksum flag.
//   The bit-serial binary-to-BCD shift and the one-digit-per-cycle Luhn
//   pass set the time from accept to o_out_valid. A new item is taken
//   once the previous result is in the output register, so the block
//   takes no new item while one is being converted or checked.
//   The output register decouples the sides: while a result waits, the
//   next item is accepted and converted. If the receiver still stalls when
//   that item finishes, the block holds it and keeps o_in_ready low.
//   Reset (synchronous, active low) returns the controller to idle and
//   drops o_out_valid; no state is kept between items.
// ----------------------------------------------------------------------------
module card_number_luhn_classifier_top #(
    parameter int MAX_DIGITS = 19
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [cnlc_pkg::IN_W-1:0]    i_card_number,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [cnlc_pkg::CLS_W-1:0]   o_issuer_class,
    output logic [cnlc_pkg::DCNT_W-1:0]  o_digit_count,
    output logic                         o_checksum_ok
);
    import cnlc_pkg::*;

    `include "card_number_luhn_classifier_top_assert.svh"

    t_cmd w_cmd;   // controller -> datapath
    t_sts w_sts;   // datapath -> controller

    // sequencer: idle, convert, Luhn pass, wait for the output slot
    cnlc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // BCD conversion, digit sum mod 10, leading digits, result registers
    cnlc_dp #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_card_number  (i_card_number),
        .o_issuer_class (o_issuer_class),
        .o_digit_count  (o_digit_count),
        .o_checksum_ok  (o_checksum_ok)
    );

    // block goes busy after taking an item
    `CNLC_ASSERT_NEXT(a_busy_after_accept, i_in_valid && o_in_ready, !o_in_ready)
    // digit count never above the converter depth
    `CNLC_ASSERT_NOW(a_count_range, o_out_valid, o_digit_count <= DCNT_W'(MAX_DIGITS))
    // a valid class needs a passing checksum
    `CNLC_ASSERT_NOW(a_class_needs_ok, o_out_valid && o_issuer_class != CLS_INVALID,
                     o_checksum_ok)
    // zero input never passes
    `CNLC_ASSERT_NOW(a_zero_fails, o_out_valid && o_digit_count == '0, !o_checksum_ok)

endmodule
